[src/scd_pkg.sv]
// ---------------------------------------------------------------------------
// scd_pkg
// Types and constants shared by the stroke cadence detector modules.
// ---------------------------------------------------------------------------
`default_nettype none
package scd_pkg;

	typedef struct packed {
		logic signed [16:0] roll;
		logic [31:0]        ts;
	} item_t;

	typedef struct packed {
		logic [16:0] amp_gate;
		logic [31:0] per_min;
		logic [31:0] per_max;
		logic [31:0] gap;
		logic [31:0] tmo;
		logic [15:0] alpha;
	} cfg_t;

	localparam int DIV_W = 36;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [31:0]      divisor;
	} div_req_t;

	localparam logic [2:0] CFG_AMP_GATE = 3'd0;
	localparam logic [2:0] CFG_PER_MIN  = 3'd1;
	localparam logic [2:0] CFG_PER_MAX  = 3'd2;
	localparam logic [2:0] CFG_GAP      = 3'd3;
	localparam logic [2:0] CFG_TMO      = 3'd4;
	localparam logic [2:0] CFG_ALPHA    = 3'd5;

	localparam logic [16:0] RST_AMP_GATE = 17'd11520;
	localparam logic [31:0] RST_PER_MIN  = 32'd400000;
	localparam logic [31:0] RST_PER_MAX  = 32'd4000000;
	localparam logic [31:0] RST_GAP      = 32'd200000;
	localparam logic [31:0] RST_TMO      = 32'd3000000;
	localparam logic [15:0] RST_ALPHA    = 16'd131;

	localparam logic [DIV_W-1:0] RATE_NUM = 36'd65536000000;
	localparam logic [17:0]      RATE_MAX = 18'h3FFFF;

endpackage
`default_nettype wire

[src/scd_queue.sv]
// ---------------------------------------------------------------------------
// scd_queue
// Two-entry request queue between the input channel and the sample engine.
// ---------------------------------------------------------------------------
`default_nettype none
module scd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire scd_pkg::item_t push_item,
	output logic               full,
	input  wire logic          pop,
	output logic               avail,
	output scd_pkg::item_t     pop_item
);

	scd_pkg::item_t mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign avail    = (cnt_q != 2'd0);
	assign pop_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

endmodule
`default_nettype wire

[src/scd_div.sv]
// ---------------------------------------------------------------------------
// scd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module scd_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire scd_pkg::div_req_t req,
	output logic                   busy,
	output logic                   done,
	output logic [scd_pkg::DIV_W-1:0] quot
);

	localparam int CW = $clog2(scd_pkg::DIV_W + 1);

	logic [scd_pkg::DIV_W-1:0] dvd_q;
	logic [31:0]               rem_q;
	logic [31:0]               dsr_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [32:0]               trial;
	logic                      fits;

	assign trial = {rem_q, dvd_q[scd_pkg::DIV_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});
	assign busy  = busy_q;
	assign done  = done_q;
	assign quot  = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(scd_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
			dvd_q <= {dvd_q[scd_pkg::DIV_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

[src/scd_engine.sv]
// ---------------------------------------------------------------------------
// scd_engine
// Per-sample sequencer: smoothing, DC removal, extremum gating, rate rings
// and mean, with a registered result stage.
// ---------------------------------------------------------------------------
`default_nettype none
module scd_engine #(
	parameter int RATE_SLOTS = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire scd_pkg::cfg_t  cfg,
	input  wire logic           q_avail,
	input  wire scd_pkg::item_t q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic                stroke_qualified,
	output logic [17:0]         rate_q16,
	output logic                rate_mature,
	output logic                timed_out
);

	localparam int HW = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;
	localparam int CW = $clog2(RATE_SLOTS + 1);
	localparam int SW = 18 + $clog2(2 * RATE_SLOTS) + 1;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_AVG  = 10'b0000000010,
		ST_ML   = 10'b0000000100,
		ST_MH   = 10'b0000001000,
		ST_FLT  = 10'b0000010000,
		ST_DET  = 10'b0000100000,
		ST_RATE = 10'b0001000000,
		ST_SUM  = 10'b0010000000,
		ST_MEAN = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} st_t;

	st_t st_q;

	logic signed [16:0] rw0_q, rw1_q;
	logic [1:0]         fill_q;
	logic               neg_q;
	logic [31:0]        ts_q;
	logic signed [17:0] avg_q;
	logic signed [34:0] diff_q;
	logic [33:0]        plo_q;
	logic signed [33:0] phi_q;
	logic signed [33:0] dc_q;
	logic               dc_rdy_q;
	logic signed [18:0] h0_q, h1_q, h2_q;
	logic [1:0]         hcnt_q;
	logic [31:0]        prev_t_q;
	logic [31:0]        cand_q;
	logic signed [18:0] pk_v_q, tr_v_q;
	logic [31:0]        pk_t_q, tr_t_q;
	logic               pk_seen_q, tr_seen_q;
	logic [17:0]        pr_q [RATE_SLOTS];
	logic [17:0]        trr_q [RATE_SLOTS];
	logic [CW-1:0]      pc_q, tc_q;
	logic [HW-1:0]      ph_q, th_q;
	logic [31:0]        lastq_q;
	logic [17:0]        mean_q;
	logic               qual_q;
	logic               to_peak_q;
	logic [SW-1:0]      sum_q;
	logic [HW-1:0]      idx_q;

	scd_pkg::div_req_t  dreq;
	logic               div_busy, div_done;
	logic [scd_pkg::DIV_W-1:0] div_quot;

	scd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// smoothing
	logic signed [18:0] raw_sum;
	logic [18:0]        raw_abs;
	logic [1:0]         fill_n;
	assign raw_sum = 19'(q_item.roll) + 19'(rw0_q) + 19'(rw1_q);
	assign raw_abs = raw_sum[18] ? 19'(-raw_sum) : raw_sum;
	assign fill_n  = (fill_q == 2'd3) ? 2'd3 : fill_q + 2'd1;

	// DC removal
	logic signed [34:0] diff_w;
	logic signed [51:0] prod;
	logic signed [33:0] dc_upd, dc_new;
	logic signed [18:0] filt;
	assign diff_w = 35'($signed({avg_q, 16'h0000})) - 35'(dc_q);
	assign prod   = (52'(phi_q) <<< 18) + $signed(52'(plo_q));
	assign dc_upd = dc_q + $signed(prod[49:16]);
	assign dc_new = dc_rdy_q ? dc_upd : $signed({avg_q, 16'h0000});
	assign filt   = 19'(avg_q) - 19'($signed(dc_new[33:16]));

	// extremum gating
	logic        is_pk, is_tr, ext_acc, try_per, in_rng;
	logic [31:0] dt;
	logic signed [19:0] swing;
	logic signed [19:0] gate_s;
	assign gate_s = $signed({3'b000, cfg.amp_gate});
	always_comb begin
		is_pk   = (hcnt_q == 2'd3) && (h2_q < h1_q) && (h1_q >= h0_q);
		is_tr   = (hcnt_q == 2'd3) && !is_pk && (h2_q > h1_q) && (h1_q <= h0_q);
		ext_acc = 1'b0;
		try_per = 1'b0;
		dt      = cand_q - pk_t_q;
		swing   = 20'(h1_q) - 20'(tr_v_q);
		if (is_pk) begin
			ext_acc = !(pk_seen_q && (dt < cfg.gap)) && !(tr_seen_q && (swing < gate_s));
			try_per = ext_acc && tr_seen_q && pk_seen_q;
		end else if (is_tr) begin
			dt      = cand_q - tr_t_q;
			swing   = 20'(pk_v_q) - 20'(h1_q);
			ext_acc = !(tr_seen_q && (dt < cfg.gap)) && !(pk_seen_q && (swing < gate_s));
			try_per = ext_acc && tr_seen_q && pk_seen_q;
		end
		in_rng = !(dt < cfg.per_min) && !(dt > cfg.per_max);
	end

	// rate push
	logic        push_en;
	logic        push_pk;
	logic [17:0] push_rate;
	assign push_pk = (st_q == ST_DET) ? is_pk : to_peak_q;
	always_comb begin
		push_en   = 1'b0;
		push_rate = scd_pkg::RATE_MAX;
		if (st_q == ST_DET && try_per && in_rng && dt == 32'd0) begin
			push_en = 1'b1;
		end else if (st_q == ST_RATE && div_done) begin
			push_en   = 1'b1;
			push_rate = (div_quot > 36'(scd_pkg::RATE_MAX)) ? scd_pkg::RATE_MAX
			                                                : div_quot[17:0];
		end
	end

	// mean accumulation
	logic [SW-1:0] sum_nx;
	logic [CW:0]   n_held;
	assign sum_nx = sum_q
		+ ((32'(idx_q) < 32'(pc_q)) ? SW'(pr_q[idx_q]) : SW'(0))
		+ ((32'(idx_q) < 32'(tc_q)) ? SW'(trr_q[idx_q]) : SW'(0));
	assign n_held = {1'b0, pc_q} + {1'b0, tc_q};

	logic out_free;
	assign out_free = !out_valid || out_ready;
	assign q_pop    = (st_q == ST_IDLE) && q_avail;

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = 36'(raw_abs);
		dreq.divisor  = 32'(fill_n);
		unique case (st_q)
			ST_IDLE: dreq.start = q_avail;
			ST_DET: begin
				dreq.start    = try_per && in_rng && (dt != 32'd0);
				dreq.dividend = scd_pkg::RATE_NUM;
				dreq.divisor  = dt;
			end
			ST_SUM: begin
				dreq.start    = (32'(idx_q) == RATE_SLOTS - 1);
				dreq.dividend = 36'(sum_nx);
				dreq.divisor  = 32'(n_held);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			rw0_q     <= '0;
			rw1_q     <= '0;
			fill_q    <= '0;
			dc_q      <= '0;
			dc_rdy_q  <= 1'b0;
			h0_q      <= '0;
			h1_q      <= '0;
			h2_q      <= '0;
			hcnt_q    <= '0;
			prev_t_q  <= '0;
			pk_v_q    <= '0;
			tr_v_q    <= '0;
			pk_t_q    <= '0;
			tr_t_q    <= '0;
			pk_seen_q <= 1'b0;
			tr_seen_q <= 1'b0;
			pc_q      <= '0;
			tc_q      <= '0;
			ph_q      <= '0;
			th_q      <= '0;
			lastq_q   <= '0;
			mean_q    <= '0;
			qual_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && st_q != ST_OUT) out_valid <= 1'b0;
			if (push_en) begin
				if (push_pk) begin
					ph_q <= (32'(ph_q) == RATE_SLOTS - 1) ? '0 : ph_q + 1'b1;
					if (32'(pc_q) < RATE_SLOTS) pc_q <= pc_q + 1'b1;
				end else begin
					th_q <= (32'(th_q) == RATE_SLOTS - 1) ? '0 : th_q + 1'b1;
					if (32'(tc_q) < RATE_SLOTS) tc_q <= tc_q + 1'b1;
				end
			end
			unique case (st_q)
				ST_IDLE: if (q_avail) begin
					rw1_q  <= rw0_q;
					rw0_q  <= q_item.roll;
					fill_q <= fill_n;
					st_q   <= ST_AVG;
				end
				ST_AVG: if (div_done) begin
					avg_q <= neg_q ? 18'(-$signed({1'b0, div_quot[16:0]}))
					               : $signed({1'b0, div_quot[16:0]});
					st_q  <= ST_ML;
				end
				ST_ML: st_q <= ST_MH;
				ST_MH: st_q <= ST_FLT;
				ST_FLT: begin
					dc_q     <= dc_new;
					dc_rdy_q <= 1'b1;
					h2_q     <= h1_q;
					h1_q     <= h0_q;
					h0_q     <= filt;
					cand_q   <= prev_t_q;
					prev_t_q <= ts_q;
					if (hcnt_q != 2'd3) hcnt_q <= hcnt_q + 2'd1;
					qual_q   <= 1'b0;
					st_q     <= ST_DET;
				end
				ST_DET: begin
					if (ext_acc && is_pk) begin
						pk_v_q    <= h1_q;
						pk_t_q    <= cand_q;
						pk_seen_q <= 1'b1;
					end
					if (ext_acc && is_tr) begin
						tr_v_q    <= h1_q;
						tr_t_q    <= cand_q;
						tr_seen_q <= 1'b1;
					end
					if (try_per && in_rng) begin
						qual_q  <= 1'b1;
						lastq_q <= cand_q;
						st_q    <= (dt == 32'd0) ? ST_SUM : ST_RATE;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_RATE: if (div_done) st_q <= ST_SUM;
				ST_SUM: if (32'(idx_q) == RATE_SLOTS - 1) st_q <= ST_MEAN;
				ST_MEAN: if (div_done) begin
					mean_q <= div_quot[17:0];
					st_q   <= ST_OUT;
				end
				ST_OUT: if (out_free) begin
					out_valid <= 1'b1;
					st_q      <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_avail) begin
			ts_q  <= q_item.ts;
			neg_q <= raw_sum[18];
		end
		if (st_q == ST_ML) begin
			diff_q <= diff_w;
			plo_q  <= {16'h0000, diff_w[17:0]} * {18'h00000, cfg.alpha};
		end
		if (st_q == ST_MH) begin
			phi_q <= 34'($signed(diff_q[34:18])) * 34'($signed({1'b0, cfg.alpha}));
		end
		if (st_q == ST_DET) begin
			to_peak_q <= is_pk;
			sum_q     <= '0;
			idx_q     <= '0;
		end
		if (st_q == ST_SUM) begin
			sum_q <= sum_nx;
			idx_q <= (32'(idx_q) == RATE_SLOTS - 1) ? idx_q : idx_q + 1'b1;
		end
		if (push_en) begin
			if (push_pk) pr_q[ph_q] <= push_rate;
			else trr_q[th_q] <= push_rate;
		end
		if (st_q == ST_OUT && out_free) begin
			stroke_qualified <= qual_q;
			rate_q16         <= mean_q;
			rate_mature      <= (32'(pc_q) >= 32'd2) && (32'(tc_q) >= 32'd2);
			timed_out        <= (ts_q - lastq_q) > cfg.tmo;
		end
	end

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !div_busy) else $error("divider started while busy");

	a_mean_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MEAN && div_done) |=> st_q == ST_OUT)
		else $error("mean did not finish");

	a_qual_held: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && qual_q) |-> (pc_q != '0 || tc_q != '0))
		else $error("qualified stroke without held rate");

endmodule
`default_nettype wire

[src/stroke_cadence_detector.sv]
// ---------------------------------------------------------------------------
// stroke_cadence_detector
// Roll-sample stroke detector with rate averaging and timeout.
// ---------------------------------------------------------------------------
// Samples enter a two-entry queue and are handled one at a time by a
// sequencer that shares a single 36-step restoring divider. Each sample
// goes through the smoothing divide, the DC filter and the extremum test; a
// sample that qualifies a stroke then goes on to the rate divide, the ring
// sum and the mean divide (with no rate divide when the period is zero).
// Results wait in an output register while the next sample is taken from
// the queue.
`default_nettype none
module stroke_cadence_detector #(
	parameter int RATE_SLOTS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [16:0] roll_angle,
	input  wire logic [31:0]        timestamp_us,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    stroke_qualified,
	output logic [17:0]             rate_q16,
	output logic                    rate_mature,
	output logic                    timed_out,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	scd_pkg::cfg_t  cfg_q;
	scd_pkg::item_t in_item, q_item;
	logic           q_full, q_avail, q_pop;

	assign cfg_ready    = 1'b1;
	assign in_ready     = !q_full;
	assign in_item.roll = roll_angle;
	assign in_item.ts   = timestamp_us;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amp_gate <= scd_pkg::RST_AMP_GATE;
			cfg_q.per_min  <= scd_pkg::RST_PER_MIN;
			cfg_q.per_max  <= scd_pkg::RST_PER_MAX;
			cfg_q.gap      <= scd_pkg::RST_GAP;
			cfg_q.tmo      <= scd_pkg::RST_TMO;
			cfg_q.alpha    <= scd_pkg::RST_ALPHA;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scd_pkg::CFG_AMP_GATE: cfg_q.amp_gate <= cfg_data[16:0];
				scd_pkg::CFG_PER_MIN:  cfg_q.per_min  <= cfg_data;
				scd_pkg::CFG_PER_MAX:  cfg_q.per_max  <= cfg_data;
				scd_pkg::CFG_GAP:      cfg_q.gap      <= cfg_data;
				scd_pkg::CFG_TMO:      cfg_q.tmo      <= cfg_data;
				scd_pkg::CFG_ALPHA:    cfg_q.alpha    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	scd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_item (in_item),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_item  (q_item)
	);

	scd_engine #(
		.RATE_SLOTS (RATE_SLOTS)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_avail          (q_avail),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.stroke_qualified (stroke_qualified),
		.rate_q16         (rate_q16),
		.rate_mature      (rate_mature),
		.timed_out        (timed_out)
	);

endmodule
`default_nettype wire
